@@ hw/rtl/binary_lrat_token_parser_top_defines.svh @@
// Assertion macros shared by the binary LRAT token parser RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BINARY_LRAT_TOKEN_PARSER_TOP_DEFINES_SVH
`define BINARY_LRAT_TOKEN_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BLRAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BLRAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/blrat_pkg.sv @@
// Types and constants for the binary LRAT token parser.
// No dependencies; imported by blrat_decode and binary_lrat_token_parser_top.
`default_nettype none

package blrat_pkg;

    localparam logic [7:0]  OP_ADD     = 8'h61;  // 'a'
    localparam logic [7:0]  OP_DEL     = 8'h64;  // 'd'
    localparam logic [31:0] ID_MAX     = 32'h7FFF_FFFF;
    localparam logic [2:0]  SHIFT_LAST = 3'd4;   // fifth varint byte

    typedef enum logic [1:0] {
        PH_OP    = 2'd0,
        PH_ID    = 2'd1,
        PH_LITS  = 2'd2,
        PH_HINTS = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        TK_ADD_ID   = 3'd0,
        TK_LITERAL  = 3'd1,
        TK_HINT_ID  = 3'd2,
        TK_DEL_ID   = 3'd3,
        TK_END_LITS = 3'd4,
        TK_END_LINE = 3'd5,
        TK_ERROR    = 3'd6
    } token_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BAD_OP   = 2'd1,
        ERR_ID_OVF   = 2'd2,
        ERR_TOO_LONG = 2'd3
    } err_code_t;

    typedef struct packed {
        phase_t      phase;
        logic        is_add;
        logic [31:0] acc;
        logic [2:0]  shift_cnt;
        err_code_t   err;
    } blrat_state_t;

    typedef struct packed {
        token_kind_t  kind;
        logic [31:0]  value;
        logic         is_add;
        err_code_t    err;
    } blrat_token_t;

endpackage

`default_nettype wire

@@ hw/rtl/blrat_decode.sv @@
// Combinational byte decoder: parser state plus one byte to next state and token.
// Depends on blrat_pkg.
`default_nettype none

module blrat_decode
(
    input  wire logic [7:0]             in_byte,
    input  wire blrat_pkg::blrat_state_t state,
    output blrat_pkg::blrat_state_t     state_next,
    output logic                        emit,
    output blrat_pkg::blrat_token_t     token
);

    import blrat_pkg::*;

    logic [31:0] acc_part;
    logic [31:0] raw;
    logic [30:0] mag;
    logic [31:0] sval;
    logic        too_long;

    // Place this byte's value bits at the current group position.
    always_comb
    begin
        case (state.shift_cnt)
            3'd0:    acc_part = {25'd0, in_byte[6:0]};
            3'd1:    acc_part = {18'd0, in_byte[6:0], 7'd0};
            3'd2:    acc_part = {11'd0, in_byte[6:0], 14'd0};
            3'd3:    acc_part = {4'd0, in_byte[6:0], 21'd0};
            default: acc_part = {in_byte[3:0], 28'd0};
        endcase
    end

    assign too_long = (state.shift_cnt >= SHIFT_LAST) && (in_byte[7:4] != 4'd0);
    assign raw      = state.acc | acc_part;
    assign mag      = raw[31:1];
    // Sign lives in the low bit.
    assign sval     = raw[0] ? (32'd0 - {1'b0, mag}) : {1'b0, mag};

    always_comb
    begin
        state_next   = state;
        emit         = 1'b0;
        token.kind   = TK_ADD_ID;
        token.value  = 32'd0;
        token.is_add = state.is_add;
        token.err    = ERR_NONE;

        if (state.err == ERR_NONE)
        begin
            unique case (state.phase)
                PH_OP:
                begin
                    state_next.acc       = 32'd0;
                    state_next.shift_cnt = 3'd0;
                    if (in_byte == OP_ADD)
                    begin
                        state_next.is_add = 1'b1;
                        state_next.phase  = PH_ID;
                    end
                    else if (in_byte == OP_DEL)
                    begin
                        state_next.is_add = 1'b0;
                        state_next.phase  = PH_HINTS;
                    end
                    else
                    begin
                        state_next.err = ERR_BAD_OP;
                        emit           = 1'b1;
                        token.kind     = TK_ERROR;
                        token.is_add   = 1'b0;
                        token.err      = ERR_BAD_OP;
                    end
                end
                default:
                begin
                    if (too_long)
                    begin
                        state_next.err = ERR_TOO_LONG;
                        emit           = 1'b1;
                        token.kind     = TK_ERROR;
                        token.is_add   = 1'b0;
                        token.err      = ERR_TOO_LONG;
                    end
                    else if (in_byte[7])
                    begin
                        state_next.acc       = raw;
                        state_next.shift_cnt = state.shift_cnt + 3'd1;
                    end
                    else
                    begin
                        state_next.acc       = 32'd0;
                        state_next.shift_cnt = 3'd0;
                        emit                 = 1'b1;
                        if (state.phase == PH_ID)
                        begin
                            if (raw > ID_MAX)
                            begin
                                state_next.err = ERR_ID_OVF;
                                token.kind     = TK_ERROR;
                                token.is_add   = 1'b0;
                                token.err      = ERR_ID_OVF;
                            end
                            else
                            begin
                                state_next.phase = PH_LITS;
                                token.kind       = TK_ADD_ID;
                                token.value      = raw;
                            end
                        end
                        else if (state.phase == PH_LITS)
                        begin
                            if (mag == 31'd0)
                            begin
                                state_next.phase = PH_HINTS;
                                token.kind       = TK_END_LITS;
                            end
                            else
                            begin
                                token.kind  = TK_LITERAL;
                                token.value = sval;
                            end
                        end
                        else
                        begin
                            if (mag == 31'd0)
                            begin
                                state_next.phase = PH_OP;
                                token.kind       = TK_END_LINE;
                            end
                            else
                            begin
                                token.kind  = state.is_add ? TK_HINT_ID : TK_DEL_ID;
                                token.value = sval;
                            end
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/binary_lrat_token_parser_top.sv @@
// Binary LRAT token parser: byte stream in, a token per completed number or error out.
// Depends on blrat_pkg, blrat_decode and binary_lrat_token_parser_top_defines.svh.
//
//   channel | direction | handshake        | payload
//   in      | request in  | in_valid/in_stall  | in_byte
//   out     | request out | out_valid/out_stall| token_kind, token_value,
//           |             |                    | line_is_addition, error_code
//
// One byte per cycle unless in_stall; each byte and its token are registered in turn.
// The input register feeds the decoder and parser state; the result register
// parts the output handshake, so a byte that yields no token never waits on it.
// Reset clears all parser state; errors stay latched until the next reset.
// in_stall rises only while the input register holds a byte whose token cannot
// yet enter a full, stalled result register.
`default_nettype none
`include "binary_lrat_token_parser_top_defines.svh"

module binary_lrat_token_parser_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         in_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              token_kind,
    output logic signed [31:0]      token_value,
    output logic                    line_is_addition,
    output logic [1:0]              error_code
);

    import blrat_pkg::*;

    logic          stage_vld_reg;
    logic          stage_vld_next;
    logic [7:0]    byte_reg;
    blrat_state_t  state_reg;
    blrat_state_t  state_next;
    logic          emit;
    blrat_token_t  token;
    logic          stage_adv;
    logic          in_acc;
    logic          out_vld_reg;
    logic          out_vld_next;
    blrat_token_t  out_tok_reg;

    blrat_decode u_decode
    (
        .in_byte    (byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (emit),
        .token      (token)
    );

    // Advance when the byte makes no token or the result register frees up.
    assign stage_adv = stage_vld_reg && (!emit || !out_vld_reg || !out_stall);
    assign in_stall  = stage_vld_reg && !stage_adv;
    assign in_acc    = in_valid && !in_stall;

    always_comb
    begin
        stage_vld_next = stage_vld_reg;
        if (in_acc)
        begin
            stage_vld_next = 1'b1;
        end
        else if (stage_adv)
        begin
            stage_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (stage_adv && emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg       <= 1'b0;
            out_vld_reg         <= 1'b0;
            state_reg.phase     <= PH_OP;
            state_reg.is_add    <= 1'b0;
            state_reg.acc       <= 32'd0;
            state_reg.shift_cnt <= 3'd0;
            state_reg.err       <= ERR_NONE;
        end
        else
        begin
            stage_vld_reg <= stage_vld_next;
            out_vld_reg   <= out_vld_next;
            if (stage_adv)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            byte_reg <= in_byte;
        end
        if (stage_adv && emit)
        begin
            out_tok_reg <= token;
        end
    end

    assign out_valid        = out_vld_reg;
    assign token_kind       = out_tok_reg.kind;
    assign token_value      = out_tok_reg.value;
    assign line_is_addition = out_tok_reg.is_add;
    assign error_code       = out_tok_reg.err;

    `BLRAT_ASSERT_NEXT(a_err_sticky, clk, rst_n, state_reg.err != ERR_NONE,
        state_reg.err == $past(state_reg.err), "latched error changed")

    `BLRAT_ASSERT_NOW(a_shift_bound, clk, rst_n, 1'b1,
        state_reg.shift_cnt <= SHIFT_LAST, "varint byte count overran")

    `BLRAT_ASSERT_NOW(a_op_clean, clk, rst_n,
        state_reg.phase == PH_OP && state_reg.err == ERR_NONE,
        state_reg.acc == 32'd0 && state_reg.shift_cnt == 3'd0,
        "accumulator not clear at line start")

    `BLRAT_ASSERT_NOW(a_err_token, clk, rst_n, out_vld_reg,
        (out_tok_reg.kind == TK_ERROR) == (out_tok_reg.err != ERR_NONE),
        "error code does not match token kind")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for binary_lrat_token_parser_top: drives binary proof bytes
// under random valid/stall gaps and checks every token against an in-bench parser model.
// Depends on blrat_pkg and the RTL of binary_lrat_token_parser_top.

module tb_top;
    import blrat_pkg::*;

    localparam int ITEM_TARGET = 1200;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        in_byte = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [2:0]        token_kind;
    logic signed [31:0] token_value;
    logic              line_is_addition;
    logic [1:0]        error_code;

    // Parser model state
    phase_t      cur_phase;
    logic        in_add_line;
    logic [31:0] acc;
    logic [2:0]  groups;
    err_code_t   latched_err;

    blrat_token_t pending_tokens[$];

    int  bytes_sent;
    int  tokens_checked;
    int  lines_sent;
    int  mismatches;
    int  cycles;
    int  hold_req;
    bit  tx_calm;
    bit  rx_calm;

    binary_lrat_token_parser_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .in_byte          (in_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .token_kind       (token_kind),
        .token_value      (token_value),
        .line_is_addition (line_is_addition),
        .error_code       (error_code)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens still due", cycles,
                     pending_tokens.size());
            $display("** binary_lrat_token_parser_top: FAILED **");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    function automatic blrat_token_t make_token(token_kind_t kind, logic [31:0] value,
                                                logic is_add, err_code_t err);
        blrat_token_t t;
        t.kind   = kind;
        t.value  = value;
        t.is_add = is_add;
        t.err    = err;
        return t;
    endfunction

    // Append a token to the list of tokens still due.
    task automatic expect_token(input blrat_token_t t);
        pending_tokens = {pending_tokens, t};
    endtask

    task automatic flag_error(err_code_t code);
        latched_err = code;
        expect_token(make_token(TK_ERROR, 32'd0, 1'b0, code));
    endtask

    // Advance the parser model by one byte; queue the token it yields, if any.
    task automatic tokenize_byte(input logic [7:0] b);
        logic [31:0] raw;
        logic [31:0] val;
        if (latched_err != ERR_NONE)
            return;
        if (cur_phase == PH_OP)
        begin
            acc    = 32'd0;
            groups = 3'd0;
            if (b == OP_ADD)
            begin
                in_add_line = 1'b1;
                cur_phase   = PH_ID;
            end
            else if (b == OP_DEL)
            begin
                in_add_line = 1'b0;
                cur_phase   = PH_HINTS;
            end
            else
                flag_error(ERR_BAD_OP);
            return;
        end
        if (groups >= SHIFT_LAST)
        begin
            if (b[7:4] != 4'd0)
            begin
                flag_error(ERR_TOO_LONG);
                return;
            end
            acc = acc | {b[3:0], 28'd0};
        end
        else
            acc = acc | ({25'd0, b[6:0]} << (7 * groups));
        if (b[7])
        begin
            groups = groups + 3'd1;
            return;
        end
        raw    = acc;
        acc    = 32'd0;
        groups = 3'd0;
        if (cur_phase == PH_ID)
        begin
            if (raw > ID_MAX)
                flag_error(ERR_ID_OVF);
            else
            begin
                cur_phase = PH_LITS;
                expect_token(make_token(TK_ADD_ID, raw, in_add_line, ERR_NONE));
            end
            return;
        end
        // sign sits in the low bit; odd raw 1 is a negative zero
        val = raw[0] ? (32'd0 - (raw >> 1)) : (raw >> 1);
        if (cur_phase == PH_LITS)
        begin
            if (val == 32'd0)
            begin
                cur_phase = PH_HINTS;
                expect_token(make_token(TK_END_LITS, 32'd0, in_add_line, ERR_NONE));
            end
            else
                expect_token(make_token(TK_LITERAL, val, in_add_line, ERR_NONE));
            return;
        end
        if (val == 32'd0)
        begin
            cur_phase = PH_OP;
            expect_token(make_token(TK_END_LINE, 32'd0, in_add_line, ERR_NONE));
        end
        else
            expect_token(make_token(in_add_line ? TK_HINT_ID : TK_DEL_ID, val,
                                    in_add_line, ERR_NONE));
    endtask

    // Offer one byte, hold it until accepted, then maybe idle.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        tokenize_byte(b);
        bytes_sent++;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Send raw as a varint, padded with extra zero groups up to five bytes.
    task automatic send_number(input logic [31:0] raw, input int pad);
        int n;
        int total;
        logic [31:0] grp;
        n = 1;
        while (n < 5 && (raw >> (7 * n)) != 32'd0)
            n++;
        total = (n + pad > 5) ? 5 : n + pad;
        for (int i = 0; i < total; i++)
        begin
            grp = (raw >> (7 * i)) & 32'h7F;
            send_byte({(i < total - 1), grp[6:0]});
        end
    endtask

    function automatic int rand_pad();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0;
    endfunction

    function automatic logic [31:0] rand_mag();
        int r;
        logic [31:0] m;
        r = $urandom_range(0, 9);
        if (r < 5)
            m = $urandom_range(1, 63);
        else if (r < 7)
            m = $urandom_range(64, 1 << 21);
        else if (r < 9)
            m = $urandom & ID_MAX;
        else
            m = ($urandom_range(0, 1) == 0) ? ID_MAX : 32'h4000_0000;
        return (m == 32'd0) ? 32'd1 : m;
    endfunction

    function automatic logic [31:0] rand_id();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return ID_MAX;
        if (r < 6)
            return $urandom_range(1, 127);
        if (r < 8)
            return $urandom_range(128, 1 << 21);
        return $urandom & ID_MAX;
    endfunction

    function automatic logic [31:0] rand_signed();
        logic [31:0] m;
        m = rand_mag();
        return {m[30:0], 1'($urandom_range(0, 1))};
    endfunction

    function automatic logic [31:0] rand_end_mark();
        return ($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0;
    endfunction

    function automatic int rand_count();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    endfunction

    task automatic send_random_line();
        int n;
        if ($urandom_range(0, 3) != 0)
        begin
            send_byte(OP_ADD);
            send_number(rand_id(), rand_pad());
            n = rand_count();
            repeat (n) send_number(rand_signed(), rand_pad());
            send_number(rand_end_mark(), rand_pad());
        end
        else
            send_byte(OP_DEL);
        n = rand_count();
        repeat (n) send_number(rand_signed(), rand_pad());
        send_number(rand_end_mark(), rand_pad());
        lines_sent++;
    endtask

    // Drop the request and idle until every due token has been taken.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stall runs, calm stretches, and requested long holds.
    initial
    begin
        int  run_left;
        bit  level;
        run_left = 0;
        level    = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req != 0)
            begin
                level    = 1'b1;
                run_left = hold_req;
                hold_req = 0;
            end
            else if (run_left == 0)
            begin
                if (rx_calm)
                begin
                    level    = 1'b0;
                    run_left = 1;
                end
                else
                begin
                    level    = ($urandom_range(0, 3) == 0);
                    run_left = level ? pick_gap() + 1 : $urandom_range(1, 8);
                end
            end
            run_left--;
            out_stall <= level;
            @(posedge clk);
        end
    end

    // Compare every accepted token with the oldest one due.
    always @(posedge clk)
    begin : check_tokens
        blrat_token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_tokens.size() == 0)
            begin
                $error("token with none due: kind %0d value %0d", token_kind, token_value);
                mismatches++;
            end
            else
            begin
                want = pending_tokens.pop_front();
                tokens_checked++;
                if (token_kind !== want.kind)
                begin
                    $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
                    mismatches++;
                end
                if (token_value !== want.value)
                begin
                    $error("token_value: expected %0d, got %0d", $signed(want.value),
                           token_value);
                    mismatches++;
                end
                if (line_is_addition !== want.is_add)
                begin
                    $error("line_is_addition: expected %0d, got %0d", want.is_add,
                           line_is_addition);
                    mismatches++;
                end
                if (error_code !== want.err)
                begin
                    $error("error_code: expected %0d, got %0d", want.err, error_code);
                    mismatches++;
                end
            end
        end
    end

    // Extreme ids and values, negative zero and a padded zero terminator.
    task automatic test_extreme_lines();
        send_byte(OP_ADD);
        send_number(ID_MAX, 0);
        send_number(32'hFFFF_FFFF, 0);
        send_number(32'd2, 0);
        send_number(32'd0, 0);
        send_number(32'hFFFF_FFFE, 0);
        send_number(32'd1, 0);
        send_byte(OP_DEL);
        send_number(32'd3, 0);
        send_number(32'd0, 1);
        lines_sent += 2;
    endtask

    // Hold the output long while bytes keep coming, so the input stalls.
    task automatic test_output_hold();
        tx_calm  = 1'b1;
        hold_req = HOLD_CYCLES;
        send_byte(OP_ADD);
        send_number($urandom_range(1, 1000), 0);
        repeat (60) send_number(rand_signed(), 0);
        send_number(32'd0, 0);
        send_number(32'd0, 0);
        lines_sent++;
        tx_calm = 1'b0;
    endtask

    // Let every token drain between lines.
    task automatic test_drain_pause();
        wait_drain();
        send_random_line();
        wait_drain();
        send_random_line();
    endtask

    task automatic test_random_lines();
        while (bytes_sent < ITEM_TARGET)
        begin
            tx_calm = ($urandom_range(0, 9) == 0);
            rx_calm = ($urandom_range(0, 9) == 0);
            send_random_line();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // One error of a random kind, then noise that must stay silent.
    task automatic test_sticky_error();
        logic [7:0] b;
        int kind;
        kind = $urandom_range(1, 3);
        if (kind == 1)
        begin
            do
                b = $urandom_range(0, 255);
            while (b == OP_ADD || b == OP_DEL);
            send_byte(b);
        end
        else if (kind == 2)
        begin
            send_byte(OP_ADD);
            send_number({1'b1, 31'($urandom)}, 0);
        end
        else
        begin
            if ($urandom_range(0, 1) == 0)
                send_byte(OP_DEL);
            else
            begin
                send_byte(OP_ADD);
                send_number(rand_id(), 0);
                repeat ($urandom_range(0, 3)) send_number(rand_signed(), 0);
            end
            repeat (4) send_byte({1'b1, 7'($urandom)});
            do
                b = $urandom_range(0, 255);
            while (b[7:4] == 4'd0);
            send_byte(b);
        end
        repeat (30) send_byte($urandom_range(0, 255));
    endtask

    initial
    begin
        cur_phase   = PH_OP;
        in_add_line = 1'b0;
        acc         = 32'd0;
        groups      = 3'd0;
        latched_err = ERR_NONE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extreme_lines();
        test_output_hold();
        test_drain_pause();
        test_random_lines();
        test_sticky_error();

        wait_drain();
        repeat (10) @(posedge clk);

        $display("%0d bytes in %0d lines, %0d tokens checked, ended on sticky error code %0d",
                 bytes_sent, lines_sent, tokens_checked, latched_err);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("** binary_lrat_token_parser_top: PASSED **");
        else
            $display("** binary_lrat_token_parser_top: FAILED **");
        $finish;
    end

endmodule

@@ binary_lrat_token_parser_top.f @@
+incdir+hw/rtl
hw/rtl/blrat_pkg.sv
hw/rtl/blrat_decode.sv
hw/rtl/binary_lrat_token_parser_top.sv
tb/tb_top.sv
